// ===== hw/rtl/vtp_pkg.sv =====
// ----------------------------------------------------------------------------
// vtp_pkg
// shared types and saturation helper for the vertex transform pipeline
// ----------------------------------------------------------------------------
package vtp_pkg;

    localparam int COORD_W = 32;
    localparam int WIDE_W  = 66;
    localparam int SIZE_W  = 13;

    typedef logic signed [COORD_W-1:0] t_q;
    typedef logic signed [2*COORD_W-1:0] t_prod;
    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_wide Q_MAX_W = t_wide'(64'sh0000_0000_7FFF_FFFF);
    localparam t_wide Q_MIN_W = -t_wide'(64'sh0000_0000_8000_0000);

    function automatic t_q sat32(input t_wide v);
        t_q res;
        if (v > Q_MAX_W) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < Q_MIN_W) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/vertex_transform_project.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_project
// 4x4 row-vector vertex transform, perspective divide and viewport mapping
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tuser: func; tdata: mat_index, mat_value, coord_x/y/z
// m_axis    out  tuser: degenerate; tdata: screen_x, screen_y
// cfg       in   we, idx (0 width, 1 height), data
//
// one transaction per cycle unless the output stalls; a vertex reaches the
// output register through the sums and the bit-per-stage reciprocal divider
// load transactions write the matrix on acceptance and give no result
// a stall on the output freezes every stage; reset restores identity
// matrix and a 640x480 viewport
// ----------------------------------------------------------------------------
module vertex_transform_project #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [3:0] mat_index, [35:4] mat_value, [67:36] coord_x,
    // [99:68] coord_y, [131:100] coord_z, [135:132] zero
    input  logic [135:0] i_s_tdata,
    // [0] func
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] screen_x, [63:32] screen_y
    output logic [63:0]  o_m_tdata,
    // [0] degenerate
    output logic         o_m_tuser,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [12:0]  i_cfg_data
);
    import vtp_pkg::*;

    localparam int QW = 2 * FRAC_BITS + 1;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    logic w_en;
    logic w_acc;

    logic [SIZE_W-1:0] r_width, r_height;
    t_q r_mat [16];

    logic  r1_v;
    t_prod r1_p [9];
    t_q    r1_t [3];

    logic r2_v;
    t_q   r2_x, r2_y, r2_d;

    logic                 r_dv_v   [QW+1];
    logic [COORD_W:0]     r_dv_rem [QW+1];
    logic [QW-1:0]        r_dv_q   [QW+1];
    logic [COORD_W-1:0]   r_dv_den [QW+1];
    logic                 r_dv_neg [QW+1];
    logic                 r_dv_dg  [QW+1];
    t_q                   r_dv_x   [QW+1];
    t_q                   r_dv_y   [QW+1];

    logic [COORD_W:0]   n_dv_rem    [QW+1];
    logic               n_dv_bit    [QW+1];

    logic r3_v, r3_dg;
    t_q   r3_r, r3_x, r3_y;
    logic r4_v, r4_dg;
    t_prod r4_px, r4_py;
    logic r5_v, r5_dg;
    t_q   r5_tx, r5_ty;
    logic r6_v, r6_dg;
    logic signed [COORD_W+SIZE_W:0] r6_mx, r6_my;
    logic r_o_v, r_o_dg;
    t_q   r_o_x, r_o_y;

    t_q n_r;
    t_wide n_sx, n_sy, n_offx, n_offy;

    assign w_en       = !r_o_v || i_m_tready;
    assign o_s_tready = w_en;
    assign w_acc      = i_s_tvalid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(640);
            r_height <= SIZE_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? (t_q'(1) <<< FRAC_BITS) : t_q'(0);
            end
        end else if (w_acc && !i_s_tuser) begin
            r_mat[i_s_tdata[3:0]] <= i_s_tdata[35:4];
        end
    end

    // stage 1: nine products
    always_ff @(posedge i_clk) begin
        t_q cx, cy, cz;
        cx = i_s_tdata[67:36];
        cy = i_s_tdata[99:68];
        cz = i_s_tdata[131:100];
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_acc && i_s_tuser;
        end
        if (w_en) begin
            r1_p[0] <= cx * r_mat[0];
            r1_p[1] <= cy * r_mat[4];
            r1_p[2] <= cz * r_mat[8];
            r1_p[3] <= cx * r_mat[1];
            r1_p[4] <= cy * r_mat[5];
            r1_p[5] <= cz * r_mat[9];
            r1_p[6] <= cx * r_mat[3];
            r1_p[7] <= cy * r_mat[7];
            r1_p[8] <= cz * r_mat[11];
            r1_t[0] <= r_mat[12];
            r1_t[1] <= r_mat[13];
            r1_t[2] <= r_mat[15];
        end
    end

    // stage 2: scaled sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
        if (w_en) begin
            r2_x <= sat32(t_wide'(r1_p[0] >>> FRAC_BITS) + t_wide'(r1_p[1] >>> FRAC_BITS)
                        + t_wide'(r1_p[2] >>> FRAC_BITS) + t_wide'(r1_t[0]));
            r2_y <= sat32(t_wide'(r1_p[3] >>> FRAC_BITS) + t_wide'(r1_p[4] >>> FRAC_BITS)
                        + t_wide'(r1_p[5] >>> FRAC_BITS) + t_wide'(r1_t[1]));
            r2_d <= sat32(t_wide'(r1_p[6] >>> FRAC_BITS) + t_wide'(r1_p[7] >>> FRAC_BITS)
                        + t_wide'(r1_p[8] >>> FRAC_BITS) + t_wide'(r1_t[2]));
        end
    end

    // restoring divider, one quotient bit per stage
    always_comb begin
        n_dv_rem[0]    = '0;
        n_dv_bit[0]    = 1'b0;
        for (int k = 1; k <= QW; k++) begin
            logic [COORD_W:0] sh;
            sh = {r_dv_rem[k-1][COORD_W-1:0], (k == 1)};
            n_dv_bit[k]    = (sh >= {1'b0, r_dv_den[k-1]});
            n_dv_rem[k]    = n_dv_bit[k] ? (sh - {1'b0, r_dv_den[k-1]}) : sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv_v[0] <= r2_v;
            for (int k = 1; k <= QW; k++) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end
        if (w_en) begin
            r_dv_rem[0] <= n_dv_rem[0];
            r_dv_q[0]   <= '0;
            r_dv_den[0] <= r2_d[COORD_W-1] ? (~r2_d + 1'b1) : r2_d;
            r_dv_neg[0] <= r2_d[COORD_W-1] | n_dv_bit[0];
            r_dv_dg[0]  <= (r2_d == '0);
            r_dv_x[0]   <= r2_x;
            r_dv_y[0]   <= r2_y;
            for (int k = 1; k <= QW; k++) begin
                r_dv_rem[k] <= n_dv_rem[k];
                r_dv_q[k]   <= {r_dv_q[k-1][QW-2:0], n_dv_bit[k]};
                r_dv_den[k] <= r_dv_den[k-1];
                r_dv_neg[k] <= r_dv_neg[k-1];
                r_dv_dg[k]  <= r_dv_dg[k-1];
                r_dv_x[k]   <= r_dv_x[k-1];
                r_dv_y[k]   <= r_dv_y[k-1];
            end
        end
    end

    // signed, saturated reciprocal
    always_comb begin
        t_wide qm;
        qm = t_wide'(r_dv_q[QW]);
        if (r_dv_neg[QW]) begin
            n_r = (qm > -Q_MIN_W) ? 32'sh8000_0000 : (~qm[COORD_W-1:0] + 1'b1);
        end else begin
            n_r = (qm > Q_MAX_W) ? 32'sh7FFF_FFFF : qm[COORD_W-1:0];
        end
    end

    always_comb begin
        n_offx = t_wide'({1'b0, r_width[SIZE_W-1:1]}) <<< FRAC_BITS;
        n_offy = t_wide'({1'b0, r_height[SIZE_W-1:1]}) <<< FRAC_BITS;
        n_sx   = t_wide'(r6_mx) + n_offx;
        n_sy   = t_wide'(r6_my) + n_offy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r3_v  <= r_dv_v[QW];
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r_o_v <= r6_v;
        end
        if (w_en) begin
            r3_r   <= n_r;
            r3_x   <= r_dv_x[QW];
            r3_y   <= r_dv_y[QW];
            r3_dg  <= r_dv_dg[QW];
            r4_px  <= r3_x * r3_r;
            r4_py  <= r3_y * r3_r;
            r4_dg  <= r3_dg;
            r5_tx  <= sat32(t_wide'(r4_px >>> FRAC_BITS));
            r5_ty  <= sat32(t_wide'(r4_py >>> FRAC_BITS));
            r5_dg  <= r4_dg;
            r6_mx  <= r5_tx * $signed({1'b0, r_width});
            r6_my  <= r5_ty * $signed({1'b0, r_height});
            r6_dg  <= r5_dg;
            r_o_x  <= r6_dg ? t_q'(0) : sat32(n_sx);
            r_o_y  <= r6_dg ? t_q'(0) : sat32(n_sy);
            r_o_dg <= r6_dg;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = {r_o_y, r_o_x};
    assign o_m_tuser  = r_o_dg;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("degenerate result with nonzero coordinates");

    a_load_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser |=> !r1_v)
        else $error("load transaction entered the pipeline");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready out of step with output stall");

endmodule
